/* hw/rtl/scan_min_speed_governor_macros.svh */
// Assertion helpers for the governor RTL.
// The asserting module must have clk and rst_n in scope.
`ifndef SCAN_MIN_SPEED_GOVERNOR_MACROS_SVH
`define SCAN_MIN_SPEED_GOVERNOR_MACROS_SVH

// Same-cycle implication
`define SMSG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("governor assertion failed");

// Next-cycle implication
`define SMSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("governor assertion failed");

`endif

/* hw/rtl/smsg_pkg.sv */
package smsg_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MAX_SPEED    = 3'd0,
    REG_SAFE_DIST    = 3'd1,
    REG_CRIT_DIST    = 3'd2,
    REG_VALID_MIN    = 3'd3,
    REG_VALID_MAX    = 3'd4
  } reg_idx_t;

  // Result zone codes
  typedef enum logic [1:0] {
    ZONE_STOP  = 2'd0,
    ZONE_SLOW  = 2'd1,
    ZONE_CLEAR = 2'd2
  } zone_t;

  // Configuration register file contents
  typedef struct packed {
    logic [11:0] speed_full;
    logic [15:0] slow_dist;
    logic [15:0] stop_dist;
    logic [15:0] valid_min;
    logic [15:0] valid_max;
  } cfg_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int          CFG_W          = 16;
  localparam int          SPEED_W        = 12;
  localparam int          TURN_W         = 9;
  localparam int          TANH_W         = 15;

  localparam logic [11:0] RST_MAX_SPEED  = 12'd800;
  localparam logic [15:0] RST_SAFE_DIST  = 16'd600;
  localparam logic [15:0] RST_CRIT_DIST  = 16'd300;
  localparam logic [15:0] RST_VALID_MIN  = 16'd0;
  localparam logic [15:0] RST_VALID_MAX  = 16'd12000;

  localparam logic [8:0]  TURN_MRAD      = 9'd300;
  localparam logic [14:0] TANH_SAT       = 15'd32767;

  // tanh(0.016) in Q2.30 and helpers for the table recurrence
  localparam logic [63:0] TANH_STEP_Q30  = 64'd17178403;
  localparam logic [63:0] ONE_Q30        = 64'd1073741824;
  localparam logic [63:0] HALF_Q15_LSB   = 64'd16384;

endpackage

/* hw/rtl/scan_min_speed_governor.sv */
// Accepts one range sample per cycle unless the queue is full; no result without sweep end.
// Result path: a sweep-end sample is folded in the front and pushed into the queue, then
// popped into zone stage, table stage, and multiply into output register.
// Throughput: one sample per cycle; a 4-entry queue absorbs output stalls until it fills.
// Reset (rst_n low, synchronous): registers take their reset values, minimum restarts,
// queue and pipeline empty.
`include "scan_min_speed_governor_macros.svh"

module scan_min_speed_governor
  import smsg_pkg::*;
#(
  parameter int TANH_ENTRIES = 256,
  parameter int RANGE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [RANGE_BITS-1:0] in_range_mm,
  input  logic                  in_sweep_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SPEED_W-1:0]    out_linear_speed,
  output logic [TURN_W-1:0]     out_turn_rate,
  output logic [1:0]            out_zone,
  output logic [RANGE_BITS-1:0] out_nearest_mm
);

  cfg_t                  cfg_r, cfg_nxt;
  q_stat_t               q_stat;
  logic                  push;
  logic [RANGE_BITS-1:0] push_nearest;
  logic                  pop;
  logic [RANGE_BITS-1:0] q_nearest;
  logic                  stop_ok;
  logic                  clear_ok;
  logic                  slow_ok;

  // Configuration register file; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_SPEED: cfg_nxt.speed_full = cfg_wdata[SPEED_W-1:0];
        REG_SAFE_DIST: cfg_nxt.slow_dist  = cfg_wdata;
        REG_CRIT_DIST: cfg_nxt.stop_dist  = cfg_wdata;
        REG_VALID_MIN: cfg_nxt.valid_min  = cfg_wdata;
        REG_VALID_MAX: cfg_nxt.valid_max  = cfg_wdata;
        default:       cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_full <= RST_MAX_SPEED;
      cfg_r.slow_dist  <= RST_SAFE_DIST;
      cfg_r.stop_dist  <= RST_CRIT_DIST;
      cfg_r.valid_min  <= RST_VALID_MIN;
      cfg_r.valid_max  <= RST_VALID_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  smsg_front #(
    .RANGE_BITS (RANGE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_range_mm  (in_range_mm),
    .in_sweep_end (in_sweep_end),
    .q_stat       (q_stat),
    .push         (push),
    .push_nearest (push_nearest)
  );

  smsg_queue #(
    .WIDTH (RANGE_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_nearest),
    .pop   (pop),
    .rdata (q_nearest),
    .stat  (q_stat)
  );

  smsg_back #(
    .RANGE_BITS   (RANGE_BITS),
    .TANH_ENTRIES (TANH_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .q_nearest        (q_nearest),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_linear_speed (out_linear_speed),
    .out_turn_rate    (out_turn_rate),
    .out_zone         (out_zone),
    .out_nearest_mm   (out_nearest_mm)
  );

  // Expected command shape per zone
  assign stop_ok  = (out_linear_speed == '0) && (out_turn_rate == '0);
  assign clear_ok = (out_linear_speed == cfg_r.speed_full) && (out_turn_rate == '0);
  assign slow_ok  = (out_turn_rate == TURN_MRAD) && (out_linear_speed <= cfg_r.speed_full);

  // Result consistency with its zone
  `SMSG_ASSERT_IMPL(a_stop_cmd, out_valid && (out_zone == ZONE_STOP), stop_ok)
  `SMSG_ASSERT_IMPL(a_clear_cmd, out_valid && (out_zone == ZONE_CLEAR), clear_ok)
  `SMSG_ASSERT_IMPL(a_slow_cmd, out_valid && (out_zone == ZONE_SLOW), slow_ok)
  // A full queue refuses the next sample
  `SMSG_ASSERT_IMPL(a_full_block, q_stat.full, !in_ready)

endmodule

/* hw/rtl/smsg_front.sv */
module smsg_front
  import smsg_pkg::*;
#(
  parameter int RANGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [RANGE_BITS-1:0] in_range_mm,
  input  logic                  in_sweep_end,
  input  q_stat_t               q_stat,
  output logic                  push,
  output logic [RANGE_BITS-1:0] push_nearest
);

  localparam int CW = (RANGE_BITS > CFG_W) ? RANGE_BITS : CFG_W;

  logic [RANGE_BITS-1:0] running_min_r, running_min_nxt;
  logic                  seen_r, seen_nxt;
  logic                  accept;
  logic                  in_win;
  logic                  take;
  logic [RANGE_BITS-1:0] upd_min;
  logic                  upd_seen;
  logic [RANGE_BITS-1:0] vmax_rng;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign vmax_rng = RANGE_BITS'(cfg.valid_max);

  // Window test and fold of this sample into the minimum
  always_comb begin
    in_win   = (CW'(in_range_mm) >= CW'(cfg.valid_min)) &&
               (CW'(in_range_mm) <= CW'(cfg.valid_max));
    take     = in_win && (!seen_r || (in_range_mm < running_min_r));
    upd_min  = take ? in_range_mm : running_min_r;
    upd_seen = seen_r || in_win;
  end

  // Sweep end hands the nearest distance to the queue
  assign push         = accept && in_sweep_end;
  assign push_nearest = upd_seen ? upd_min : vmax_rng;

  always_comb begin
    running_min_nxt = running_min_r;
    seen_nxt        = seen_r;
    if (accept) begin
      if (in_sweep_end) begin
        running_min_nxt = vmax_rng;
        seen_nxt        = 1'b0;
      end else begin
        running_min_nxt = upd_min;
        seen_nxt        = upd_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_min_r <= RANGE_BITS'(RST_VALID_MAX);
      seen_r        <= 1'b0;
    end else begin
      running_min_r <= running_min_nxt;
      seen_r        <= seen_nxt;
    end
  end

endmodule

/* hw/rtl/smsg_queue.sv */
module smsg_queue
  import smsg_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == (PW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hw/rtl/smsg_back.sv */
module smsg_back
  import smsg_pkg::*;
#(
  parameter int RANGE_BITS   = 16,
  parameter int TANH_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  q_stat_t               q_stat,
  input  logic [RANGE_BITS-1:0] q_nearest,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SPEED_W-1:0]    out_linear_speed,
  output logic [TURN_W-1:0]     out_turn_rate,
  output logic [1:0]            out_zone,
  output logic [RANGE_BITS-1:0] out_nearest_mm
);

  localparam int CW  = (RANGE_BITS > CFG_W) ? RANGE_BITS : CFG_W;
  localparam int IW  = CW - 4;
  localparam int TIW = $clog2(TANH_ENTRIES);

  typedef logic [TANH_ENTRIES-1:0][TANH_W-1:0] tanh_tab_t;

  // Q0.15 tanh table from the Q2.30 addition recurrence, built at elaboration
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] rem;
    tab = '0;
    t   = '0;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      e = (t + HALF_Q15_LSB) >> 15;
      tab[i] = (e > 64'(TANH_SAT)) ? TANH_SAT : e[TANH_W-1:0];
      num = (t + TANH_STEP_Q30) << 30;
      den = ONE_Q30 + ((t * TANH_STEP_Q30) >> 30);
      // restoring long division
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      t = q;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

  logic                  adv;

  // stage 1: zone decision and table index
  logic                  s1_valid_r, s1_valid_nxt;
  zone_t                 s1_zone_r, s1_zone_nxt;
  logic [RANGE_BITS-1:0] s1_nearest_r;
  logic                  s1_in_tab_r, s1_in_tab_nxt;
  logic [TIW-1:0]        s1_tidx_r, s1_tidx_nxt;

  // stage 2: table value
  logic                  s2_valid_r;
  zone_t                 s2_zone_r;
  logic [RANGE_BITS-1:0] s2_nearest_r;
  logic [TANH_W-1:0]     s2_t_r, s2_t_nxt;

  // stage 3: output register
  logic                  out_valid_r;
  zone_t                 out_zone_r, out_zone_nxt;
  logic [SPEED_W-1:0]    out_speed_r, out_speed_nxt;
  logic [TURN_W-1:0]     out_turn_r, out_turn_nxt;
  logic [RANGE_BITS-1:0] out_nearest_r;

  logic [CW-1:0]         n_ext;
  logic [CW-1:0]         crit_ext;
  logic [CW-1:0]         safe_ext;
  logic [CW-1:0]         err;
  logic [IW-1:0]         idx;
  logic [SPEED_W+TANH_W-1:0] prod;

  // Whole pipeline moves when the output slot is free or being taken
  assign adv          = !out_valid_r || out_ready;
  assign pop          = adv && !q_stat.empty;
  assign s1_valid_nxt = pop;

  always_comb begin
    n_ext    = CW'(q_nearest);
    crit_ext = CW'(cfg.stop_dist);
    safe_ext = CW'(cfg.slow_dist);
    err      = n_ext - crit_ext;
    idx      = err[CW-1:4];
    if (n_ext <= crit_ext) begin
      s1_zone_nxt = ZONE_STOP;
    end else if (n_ext <= safe_ext) begin
      s1_zone_nxt = ZONE_SLOW;
    end else begin
      s1_zone_nxt = ZONE_CLEAR;
    end
    s1_in_tab_nxt = ({1'b0, idx} < (IW+1)'(TANH_ENTRIES));
    s1_tidx_nxt   = s1_in_tab_nxt ? idx[TIW-1:0] : '0;
  end

  // Table read, saturating beyond the last entry
  assign s2_t_nxt = s1_in_tab_r ? TANH_TAB[s1_tidx_r] : TANH_SAT;

  // Speed command from zone
  always_comb begin
    prod          = (SPEED_W+TANH_W)'(cfg.speed_full) * (SPEED_W+TANH_W)'(s2_t_r);
    out_zone_nxt  = s2_zone_r;
    out_speed_nxt = '0;
    out_turn_nxt  = '0;
    case (s2_zone_r)
      ZONE_STOP: begin
        out_speed_nxt = '0;
        out_turn_nxt  = '0;
      end
      ZONE_SLOW: begin
        out_speed_nxt = prod[SPEED_W+TANH_W-1:TANH_W];
        out_turn_nxt  = TURN_MRAD;
      end
      ZONE_CLEAR: begin
        out_speed_nxt = cfg.speed_full;
        out_turn_nxt  = '0;
      end
      default: begin
        out_speed_nxt = '0;
        out_turn_nxt  = '0;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_zone_r     <= s1_zone_nxt;
      s1_nearest_r  <= q_nearest;
      s1_in_tab_r   <= s1_in_tab_nxt;
      s1_tidx_r     <= s1_tidx_nxt;
      s2_zone_r     <= s1_zone_r;
      s2_nearest_r  <= s1_nearest_r;
      s2_t_r        <= s2_t_nxt;
      out_zone_r    <= out_zone_nxt;
      out_speed_r   <= out_speed_nxt;
      out_turn_r    <= out_turn_nxt;
      out_nearest_r <= s2_nearest_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_linear_speed = out_speed_r;
  assign out_turn_rate    = out_turn_r;
  assign out_zone         = out_zone_r;
  assign out_nearest_mm   = out_nearest_r;

endmodule
